/* hdl/dnle_pkg.sv */
// Shared constants and types for the DNS name label encoder.
// No dependencies; every other file imports this package.
`default_nettype none

package dnle_pkg;

   // Longest label kept; characters beyond it are dropped
   localparam int MAX_LABEL = 32;

   // Byte counter must hold MAX_LABEL itself, index only up to MAX_LABEL-1
   localparam int LEN_W = $clog2(MAX_LABEL + 1);
   localparam int IDX_W = (MAX_LABEL > 1) ? $clog2(MAX_LABEL) : 1;

   localparam int CHAR_W = 8;

   localparam logic [CHAR_W-1:0] DOT_CHAR  = 8'h2E;
   localparam logic [CHAR_W-1:0] TERM_BYTE = 8'h00;

   // Commands from controller to datapath
   typedef struct packed {
      logic buf_char;   // store the accepted character
      logic load_len;   // load length byte into output, start flush
      logic len_last;   // length byte closes the run
      logic load_data;  // load next label byte into output
      logic data_last;  // label byte closes the run
      logic load_term;  // load terminating zero, clear overflow
   } cmd_type;

   // Status from datapath to controller
   typedef struct packed {
      logic can_load;   // output register free this cycle
      logic is_dot;     // pending item is a dot
      logic is_end;     // pending item ends the name
      logic len_zero;   // buffered label is empty
      logic last_idx;   // label byte in flight is the final one
   } stat_type;

endpackage

`default_nettype wire

/* hdl/dnle_req_if.sv */
// Input channel of the DNS name label encoder: one character item per transfer.
// Depends on dnle_pkg.
`default_nettype none

interface dnle_req_if import dnle_pkg::*;;
   logic              valid;
   logic              ready;
   logic [CHAR_W-1:0] char_in;
   logic              name_end;

   modport source (output valid, output char_in, output name_end, input ready);
   modport sink   (input valid, input char_in, input name_end, output ready);
endinterface

`default_nettype wire

/* hdl/dnle_rsp_if.sv */
// Result channel of the DNS name label encoder: one encoded byte per transfer.
// Depends on dnle_pkg.
`default_nettype none

interface dnle_rsp_if import dnle_pkg::*;;
   logic              valid;
   logic              ready;
   logic [CHAR_W-1:0] out_byte;
   logic              run_last;
   logic              label_overflow;

   modport source (output valid, output out_byte, output run_last,
                   output label_overflow, input ready);
   modport sink   (input valid, input out_byte, input run_last,
                   input label_overflow, output ready);
endinterface

`default_nettype wire

/* hdl/dns_name_label_encoder.sv */
// DNS name label encoder, top level: ties sequencer and datapath to the channels.
// Depends on dnle_pkg, dnle_req_if, dnle_rsp_if, dnle_ctrl and dnle_dpath.
//
// Feed a host name one character item at a time; the block emits DNS wire
// labels on the result channel. An ordinary character is buffered and gives
// no result. A dot emits the buffered label's length byte and then its n
// bytes, one result per cycle unless the result channel stalls, and holds
// off the input meanwhile; an end item emits the same plus a terminating
// zero byte marked run_last. The label buffer has one write and one
// registered read port. Labels over MAX_LABEL bytes are truncated and set
// label_overflow, which rides on every result until the name ends.
`default_nettype none

module dns_name_label_encoder import dnle_pkg::*; (
   input  wire logic  clock,
   input  wire logic  reset,
   dnle_req_if.sink   req_chan,
   dnle_rsp_if.source rsp_chan
);

   cmd_type  cmd;
   stat_type stat;
   logic     req_ready;

   dnle_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   dnle_dpath u_dpath (
      .clock          (clock),
      .reset          (reset),
      .char_in        (req_chan.char_in),
      .name_end       (req_chan.name_end),
      .cmd            (cmd),
      .stat           (stat),
      .rsp_ready      (rsp_chan.ready),
      .rsp_valid      (rsp_chan.valid),
      .out_byte       (rsp_chan.out_byte),
      .run_last       (rsp_chan.run_last),
      .label_overflow (rsp_chan.label_overflow)
   );

   assign req_chan.ready = req_ready;

endmodule

`default_nettype wire

/* hdl/dnle_ctrl.sv */
// Sequencer of the DNS name label encoder: accepts items and walks each flush.
// Depends on dnle_pkg; drives dnle_dpath through cmd_type.
`default_nettype none

module dnle_ctrl import dnle_pkg::*; (
   input  wire logic     clock,
   input  wire logic     reset,
   input  wire logic     req_valid,
   output logic          req_ready,
   input  wire stat_type stat,
   output cmd_type       cmd
);

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_DATA = 2'd1;
   localparam logic [1:0] ST_TERM = 2'd2;

   logic [1:0] state_ff, state_in;
   logic       end_ff, end_in;
   logic       accept;

   assign req_ready = (state_ff == ST_IDLE) && stat.can_load;
   assign accept    = req_valid && req_ready;

   // Next state and commands
   always_comb begin
      state_in = state_ff;
      end_in   = end_ff;
      cmd      = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (stat.is_end || stat.is_dot) begin
                  cmd.load_len = 1'b1;
                  cmd.len_last = stat.is_dot && !stat.is_end && stat.len_zero;
                  end_in       = stat.is_end;
                  if (!stat.len_zero) begin
                     state_in = ST_DATA;
                  end else if (stat.is_end) begin
                     state_in = ST_TERM;
                  end
               end else begin
                  cmd.buf_char = 1'b1;
               end
            end
         end
         ST_DATA: begin
            if (stat.can_load) begin
               cmd.load_data = 1'b1;
               cmd.data_last = !end_ff && stat.last_idx;
               if (stat.last_idx) begin
                  state_in = end_ff ? ST_TERM : ST_IDLE;
               end
            end
         end
         ST_TERM: begin
            if (stat.can_load) begin
               cmd.load_term = 1'b1;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         end_ff   <= 1'b0;
      end else begin
         state_ff <= state_in;
         end_ff   <= end_in;
      end
   end

endmodule

`default_nettype wire

/* hdl/dnle_dpath.sv */
// Datapath of the DNS name label encoder: label buffer, counters, output register.
// Depends on dnle_pkg; commanded by dnle_ctrl.
`default_nettype none

module dnle_dpath import dnle_pkg::*; (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic [CHAR_W-1:0] char_in,
   input  wire logic              name_end,
   input  wire cmd_type           cmd,
   output stat_type               stat,
   input  wire logic              rsp_ready,
   output logic                   rsp_valid,
   output logic [CHAR_W-1:0]      out_byte,
   output logic                   run_last,
   output logic                   label_overflow
);

   logic [CHAR_W-1:0] label_mem [MAX_LABEL];
   logic [CHAR_W-1:0] rd_data_ff;
   logic [IDX_W-1:0]  rd_addr;

   logic [LEN_W-1:0]  len_ff;
   logic [LEN_W-1:0]  cnt_ff;
   logic [IDX_W-1:0]  idx_ff;
   logic              ovf_ff;

   logic              valid_ff;
   logic [CHAR_W-1:0] byte_ff;
   logic              last_ff;
   logic              ovf_out_ff;

   logic              room;

   assign room = len_ff < LEN_W'(MAX_LABEL);

   // Status back to the controller
   assign stat.can_load = !valid_ff || rsp_ready;
   assign stat.is_dot   = char_in == DOT_CHAR;
   assign stat.is_end   = name_end;
   assign stat.len_zero = len_ff == '0;
   assign stat.last_idx = (LEN_W'(idx_ff) + LEN_W'(1)) == cnt_ff;

   // Read address runs one byte ahead of the output register
   always_comb begin
      priority if (cmd.load_len) begin
         rd_addr = '0;
      end else if (cmd.load_data) begin
         rd_addr = idx_ff + IDX_W'(1);
      end else begin
         rd_addr = idx_ff;
      end
   end

   // Label buffer: one write, one registered read
   always_ff @(posedge clock) begin
      if (cmd.buf_char && room) begin
         label_mem[len_ff[IDX_W-1:0]] <= char_in;
      end
      rd_data_ff <= label_mem[rd_addr];
   end

   // Label length, flush counters and sticky overflow
   always_ff @(posedge clock) begin
      if (reset) begin
         len_ff <= '0;
         cnt_ff <= '0;
         idx_ff <= '0;
         ovf_ff <= 1'b0;
      end else begin
         if (cmd.buf_char) begin
            if (room) begin
               len_ff <= len_ff + LEN_W'(1);
            end else begin
               ovf_ff <= 1'b1;
            end
         end
         if (cmd.load_len) begin
            cnt_ff <= len_ff;
            len_ff <= '0;
            idx_ff <= '0;
         end
         if (cmd.load_data) begin
            idx_ff <= idx_ff + IDX_W'(1);
         end
         if (cmd.load_term) begin
            ovf_ff <= 1'b0;
         end
      end
   end

   // Output register: hold until taken
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (cmd.load_len || cmd.load_data || cmd.load_term) begin
         valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      priority if (cmd.load_len) begin
         byte_ff <= CHAR_W'(len_ff);
         last_ff <= cmd.len_last;
      end else if (cmd.load_data) begin
         byte_ff <= rd_data_ff;
         last_ff <= cmd.data_last;
      end else if (cmd.load_term) begin
         byte_ff <= TERM_BYTE;
         last_ff <= 1'b1;
      end
      if (cmd.load_len || cmd.load_data || cmd.load_term) begin
         ovf_out_ff <= ovf_ff;
      end
   end

   assign rsp_valid      = valid_ff;
   assign out_byte       = byte_ff;
   assign run_last       = last_ff;
   assign label_overflow = ovf_out_ff;

endmodule

`default_nettype wire
